// ===== hdl/nmea_lat_pkg.sv =====
`default_nettype none

package nmea_lat_pkg;

    // Characters that steer the parser.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Token numbers within an RMC sentence (counted from zero).
    localparam logic [3:0] TOK_HEADER = 4'd0;
    localparam logic [3:0] TOK_STATUS = 4'd3;
    localparam logic [3:0] TOK_LAT    = 4'd4;
    localparam logic [3:0] TOK_FRAC   = 4'd5;
    localparam logic [3:0] TOK_HEMI   = 4'd6;
    localparam logic [3:0] TOK_MAX    = 4'd15;

    localparam logic [7:0] POS_MAX    = 8'hFF;
    localparam logic [7:0] TAG_LEN    = 8'd5;

    // One result item.
    typedef struct packed {
        logic [6:0] lat_degrees;
        logic [7:0] lat_minutes;
        logic [9:0] lat_thousandths;
        logic       lat_south;
        logic       line_was_sentence;
        logic       line_was_rmc;
        logic       fix_updated;
    } fix_result_t;

    // Expected header text, one character per position.
    function automatic logic [7:0] rmc_tag_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h47;
            3'd1:    ch = 8'h50;
            3'd2:    ch = 8'h52;
            3'd3:    ch = 8'h4D;
            3'd4:    ch = 8'h43;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nmea_lat_byte_if.sv =====
`default_nettype none

interface nmea_lat_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/nmea_lat_fix_if.sv =====
`default_nettype none

interface nmea_lat_fix_if;
    logic       valid;
    logic       ready;
    logic [6:0] lat_degrees;
    logic [7:0] lat_minutes;
    logic [9:0] lat_thousandths;
    logic       lat_south;
    logic       line_was_sentence;
    logic       line_was_rmc;
    logic       fix_updated;

    modport source (
        output valid, output lat_degrees, output lat_minutes, output lat_thousandths,
        output lat_south, output line_was_sentence, output line_was_rmc,
        output fix_updated, input ready
    );
    modport sink (
        input valid, input lat_degrees, input lat_minutes, input lat_thousandths,
        input lat_south, input line_was_sentence, input line_was_rmc,
        input fix_updated, output ready
    );
endinterface

`default_nettype wire

// ===== hdl/nmea_lat_in_stage.sv =====
`default_nettype none

module nmea_lat_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nmea_lat_byte_if.sink   rx,
    input  wire logic       take,
    output logic            cur_valid,
    output logic [7:0]      cur_byte
);
    import nmea_lat_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register can refill in the same cycle its byte is consumed.
    assign rx.ready   = !valid_reg || take;
    assign cur_valid  = valid_reg;
    assign cur_byte   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx.ready)
        begin
            valid_next = rx.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nmea_lat_core.sv =====
`default_nettype none

module nmea_lat_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [7:0]           byte_in,
    output logic                      result_valid,
    output nmea_lat_pkg::fix_result_t result
);
    import nmea_lat_pkg::*;

    // Line state.
    logic       lpz_reg, lpz_next;
    logic [3:0] tok_idx_reg, tok_idx_next;
    logic [7:0] pos_reg, pos_next;
    logic       in_tok_reg, in_tok_next;
    logic       hdr_reg, hdr_next;
    logic       status_reg, status_next;
    logic       stop_reg, stop_next;
    logic [6:0] deg_reg, deg_next;
    logic [7:0] min_reg, min_next;
    logic [9:0] frac_reg, frac_next;
    logic [1:0] hemi_reg, hemi_next;
    logic       sent_reg, sent_next;

    // Latitude of the last valid fix.
    logic [6:0] sv_deg_reg, sv_deg_next;
    logic [7:0] sv_min_reg, sv_min_next;
    logic [9:0] sv_frac_reg, sv_frac_next;
    logic       sv_south_reg, sv_south_next;

    logic       delim;
    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] tok;
    logic       rmc;
    logic       fix;

    assign delim    = (byte_in == CH_DOLLAR) || (byte_in == CH_COMMA) || (byte_in == CH_DOT);
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign digit    = byte_in[3:0];
    assign result_valid = take && (byte_in == CH_NL);

    // Per-byte update of the tokenizer and the field accumulators.
    always_comb
    begin
        lpz_next      = lpz_reg;
        tok_idx_next  = tok_idx_reg;
        pos_next      = pos_reg;
        in_tok_next   = in_tok_reg;
        hdr_next      = hdr_reg;
        status_next   = status_reg;
        stop_next     = stop_reg;
        deg_next      = deg_reg;
        min_next      = min_reg;
        frac_next     = frac_reg;
        hemi_next     = hemi_reg;
        sent_next     = sent_reg;
        sv_deg_next   = sv_deg_reg;
        sv_min_next   = sv_min_reg;
        sv_frac_next  = sv_frac_reg;
        sv_south_next = sv_south_reg;
        tok           = tok_idx_reg - 4'd1;
        rmc           = 1'b0;
        fix           = 1'b0;

        if (byte_in != CH_NUL)
        begin
            // The first character decides whether this is a sentence.
            if (lpz_reg)
            begin
                lpz_next  = 1'b0;
                sent_next = (byte_in == CH_DOLLAR);
                hdr_next  = sent_next;
            end

            if (delim)
            begin
                // A header token shorter than the tag cannot match.
                if (in_tok_reg && (tok_idx_reg == 4'd1) && (pos_reg < TAG_LEN))
                begin
                    hdr_next = 1'b0;
                end
                in_tok_next = 1'b0;
            end
            else
            begin
                if (!in_tok_reg)
                begin
                    in_tok_next = 1'b1;
                    if (tok_idx_reg != TOK_MAX)
                    begin
                        tok_idx_next = tok_idx_reg + 4'd1;
                    end
                    pos_next  = '0;
                    stop_next = 1'b0;
                end
                tok = tok_idx_next - 4'd1;
                if (sent_next)
                begin
                    case (tok)
                        TOK_HEADER:
                        begin
                            if ((pos_next < TAG_LEN) && (byte_in != rmc_tag_char(pos_next[2:0])))
                            begin
                                hdr_next = 1'b0;
                            end
                        end
                        TOK_STATUS:
                        begin
                            if (hdr_next && (pos_next == 8'd0))
                            begin
                                status_next = (byte_in == CH_A);
                            end
                        end
                        TOK_LAT:
                        begin
                            if (status_next)
                            begin
                                if (pos_next == 8'd2)
                                begin
                                    stop_next = 1'b0;
                                end
                                if (!stop_next && is_digit)
                                begin
                                    if (pos_next < 8'd2)
                                    begin
                                        deg_next = 7'((11'(deg_next) * 11'd10) + 11'(digit));
                                    end
                                    else
                                    begin
                                        min_next = 8'((12'(min_next) * 12'd10) + 12'(digit));
                                    end
                                end
                                else
                                begin
                                    stop_next = 1'b1;
                                end
                            end
                        end
                        TOK_FRAC:
                        begin
                            if (status_next && (pos_next < 8'd3))
                            begin
                                if (!stop_next && is_digit)
                                begin
                                    frac_next = 10'((14'(frac_next) * 14'd10) + 14'(digit));
                                end
                                else
                                begin
                                    stop_next = 1'b1;
                                end
                            end
                        end
                        TOK_HEMI:
                        begin
                            if (status_next && (pos_next == 8'd0))
                            begin
                                hemi_next = {(byte_in == CH_S), 1'b1};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (pos_next != POS_MAX)
                    begin
                        pos_next = pos_next + 8'd1;
                    end
                end
            end

            // End of line: commit the fix and start a fresh line.
            if (byte_in == CH_NL)
            begin
                rmc = sent_next && hdr_next;
                fix = rmc && status_next && hemi_next[0];
                if (fix)
                begin
                    sv_deg_next   = deg_next;
                    sv_min_next   = min_next;
                    sv_frac_next  = frac_next;
                    sv_south_next = hemi_next[1];
                end
            end
        end

        result.lat_degrees       = sv_deg_next;
        result.lat_minutes       = sv_min_next;
        result.lat_thousandths   = sv_frac_next;
        result.lat_south         = sv_south_next;
        result.line_was_sentence = sent_next;
        result.line_was_rmc      = rmc;
        result.fix_updated       = fix;

        if (byte_in == CH_NL)
        begin
            lpz_next     = 1'b1;
            tok_idx_next = '0;
            pos_next     = '0;
            in_tok_next  = 1'b0;
            hdr_next     = 1'b0;
            status_next  = 1'b0;
            stop_next    = 1'b0;
            deg_next     = '0;
            min_next     = '0;
            frac_next    = '0;
            hemi_next    = '0;
            sent_next    = 1'b0;
        end
    end

    // State advances only on a consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpz_reg      <= 1'b1;
            tok_idx_reg  <= '0;
            pos_reg      <= '0;
            in_tok_reg   <= 1'b0;
            hdr_reg      <= 1'b0;
            status_reg   <= 1'b0;
            stop_reg     <= 1'b0;
            deg_reg      <= '0;
            min_reg      <= '0;
            frac_reg     <= '0;
            hemi_reg     <= '0;
            sent_reg     <= 1'b0;
            sv_deg_reg   <= '0;
            sv_min_reg   <= '0;
            sv_frac_reg  <= '0;
            sv_south_reg <= 1'b0;
        end
        else if (take)
        begin
            lpz_reg      <= lpz_next;
            tok_idx_reg  <= tok_idx_next;
            pos_reg      <= pos_next;
            in_tok_reg   <= in_tok_next;
            hdr_reg      <= hdr_next;
            status_reg   <= status_next;
            stop_reg     <= stop_next;
            deg_reg      <= deg_next;
            min_reg      <= min_next;
            frac_reg     <= frac_next;
            hemi_reg     <= hemi_next;
            sent_reg     <= sent_next;
            sv_deg_reg   <= sv_deg_next;
            sv_min_reg   <= sv_min_next;
            sv_frac_reg  <= sv_frac_next;
            sv_south_reg <= sv_south_next;
        end
    end

    // A header match is only ever held on a line that began with a dollar sign.
    a_hdr_needs_sentence: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_reg |-> sent_reg)
        else $error("header match without sentence start");

    // Within a line the token count never goes backward.
    a_tok_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (byte_in != CH_NL)) |=> (tok_idx_reg >= $past(tok_idx_reg)))
        else $error("token index decreased within a line");

    // A committed fix always comes from an RMC sentence.
    a_fix_is_rmc: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.fix_updated) |-> (result.line_was_rmc && result.line_was_sentence))
        else $error("fix reported on a non-RMC line");

endmodule

`default_nettype wire

// ===== hdl/nmea_lat_out_stage.sv =====
`default_nettype none

module nmea_lat_out_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire nmea_lat_pkg::fix_result_t   result,
    output logic                             free,
    nmea_lat_fix_if.source                   fix
);
    import nmea_lat_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    fix_result_t data_reg;

    // The register can take a new result when empty or when being drained.
    assign free = !valid_reg || fix.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= result;
        end
    end

    assign fix.valid             = valid_reg;
    assign fix.lat_degrees       = data_reg.lat_degrees;
    assign fix.lat_minutes       = data_reg.lat_minutes;
    assign fix.lat_thousandths   = data_reg.lat_thousandths;
    assign fix.lat_south         = data_reg.lat_south;
    assign fix.line_was_sentence = data_reg.line_was_sentence;
    assign fix.line_was_rmc      = data_reg.line_was_rmc;
    assign fix.fix_updated       = data_reg.fix_updated;

endmodule

`default_nettype wire

// ===== hdl/nmea_lat_top.sv =====
// Path: an accepted byte is held in the input register and parsed from there into the
// core's line state; a newline's result is loaded into the result register and offered on fix.
// Throughput: one byte per cycle, set by the combinational parse between the input and
// result registers; only a newline waits when the result register is still full.
// Reset (rst_n, asynchronous, active low) empties both registers, starts a new line
// and clears the saved latitude to zero.
`default_nettype none

module nmea_rmc_latitude_parser_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nmea_lat_byte_if.sink   rx,
    nmea_lat_fix_if.source  fix
);
    import nmea_lat_pkg::*;

    logic        cur_valid;
    logic [7:0]  cur_byte;
    logic        take;
    logic        out_free;
    logic        result_valid;
    fix_result_t result;

    // A newline is consumed only when its result has a place to go.
    assign take = cur_valid && ((cur_byte != CH_NL) || out_free);

    nmea_lat_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .take      (take),
        .cur_valid (cur_valid),
        .cur_byte  (cur_byte)
    );

    nmea_lat_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .byte_in      (cur_byte),
        .result_valid (result_valid),
        .result       (result)
    );

    nmea_lat_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (result_valid),
        .result (result),
        .free   (out_free),
        .fix    (fix)
    );

endmodule

`default_nettype wire

// ===== test/nmea_rmc_latitude_checker.sv =====
`timescale 1ns / 100ps

module nmea_rmc_latitude_checker (
    input  logic      clk,
    input  logic      rst_n,
    nmea_lat_byte_if  rx,
    nmea_lat_fix_if   fix,
    output int        fail_count,
    output int        pending_fixes
);
    import nmea_lat_pkg::*;

    localparam logic [39:0] RMC_HEADER   = "GPRMC";
    localparam int          REPORT_LIMIT = 10;

    // Line parsing state of the predictor.
    logic       at_line_start;
    logic [3:0] tokens_started;
    logic [7:0] token_pos;
    logic       token_open;
    logic       header_ok;
    logic       status_ok;
    logic       digits_done;
    logic [6:0] deg_acc;
    logic [7:0] min_acc;
    logic [9:0] frac_acc;
    logic       hemi_present;
    logic       hemi_south;
    logic       line_is_sentence;

    // Latitude kept across lines.
    logic [6:0] saved_degrees;
    logic [7:0] saved_minutes;
    logic [9:0] saved_thousandths;
    logic       saved_south;

    fix_result_t expected_fixes[$];
    int          mismatches;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Decimal shift-in; callers keep only as many bits as their field holds.
    function automatic logic [9:0] append_digit(input logic [9:0] acc, input logic [7:0] c);
        return acc * 10'd10 + 10'(c - CH_ZERO);
    endfunction

    task automatic clear_line_state();
        at_line_start    = 1'b1;
        tokens_started   = '0;
        token_pos        = '0;
        token_open       = 1'b0;
        header_ok        = 1'b0;
        status_ok        = 1'b0;
        digits_done      = 1'b0;
        deg_acc          = '0;
        min_acc          = '0;
        frac_acc         = '0;
        hemi_present     = 1'b0;
        hemi_south       = 1'b0;
        line_is_sentence = 1'b0;
    endtask

    // Advances the parser by one received character and reports the line result on newline.
    task automatic parse_nmea_char(input logic [7:0] c, output logic produced,
                                   output fix_result_t result);
        logic [3:0] tok;
        logic       rmc;
        logic       updated;
        produced = 1'b0;
        result   = '0;
        if (c != CH_NUL)
        begin
            if (at_line_start)
            begin
                at_line_start    = 1'b0;
                line_is_sentence = (c == CH_DOLLAR);
                header_ok        = line_is_sentence;
            end

            // Delimiters close the current token; runs of them make no empty tokens.
            if (c == CH_DOLLAR || c == CH_COMMA || c == CH_DOT)
            begin
                if (token_open && tokens_started == 4'd1 && token_pos < TAG_LEN)
                    header_ok = 1'b0;
                token_open = 1'b0;
            end
            else
            begin
                if (!token_open)
                begin
                    token_open = 1'b1;
                    if (tokens_started != TOK_MAX)
                        tokens_started = tokens_started + 4'd1;
                    token_pos   = '0;
                    digits_done = 1'b0;
                end
                if (line_is_sentence)
                begin
                    tok = tokens_started - 4'd1;
                    case (tok)
                        TOK_HEADER:
                        begin
                            if (token_pos < TAG_LEN)
                            begin
                                if (c != RMC_HEADER[8 * (4 - int'(token_pos)) +: 8])
                                    header_ok = 1'b0;
                            end
                        end
                        TOK_STATUS:
                        begin
                            if (header_ok && token_pos == 8'd0)
                                status_ok = (c == CH_A);
                        end
                        TOK_LAT:
                        begin
                            if (status_ok)
                            begin
                                // Minutes start a fresh digit run at the third character.
                                if (token_pos == 8'd2)
                                    digits_done = 1'b0;
                                if (!digits_done && is_digit(c))
                                begin
                                    if (token_pos < 8'd2)
                                        deg_acc = 7'(append_digit(10'(deg_acc), c));
                                    else
                                        min_acc = 8'(append_digit(10'(min_acc), c));
                                end
                                else
                                    digits_done = 1'b1;
                            end
                        end
                        TOK_FRAC:
                        begin
                            if (status_ok && token_pos < 8'd3)
                            begin
                                if (!digits_done && is_digit(c))
                                    frac_acc = append_digit(frac_acc, c);
                                else
                                    digits_done = 1'b1;
                            end
                        end
                        TOK_HEMI:
                        begin
                            if (status_ok && token_pos == 8'd0)
                            begin
                                hemi_present = 1'b1;
                                hemi_south   = (c == CH_S);
                            end
                        end
                        default: ;
                    endcase
                    if (token_pos != POS_MAX)
                        token_pos = token_pos + 8'd1;
                end
            end

            // Newline ends the line: commit the latitude if it is complete.
            if (c == CH_NL)
            begin
                rmc     = line_is_sentence && header_ok;
                updated = rmc && status_ok && hemi_present;
                if (updated)
                begin
                    saved_degrees     = deg_acc;
                    saved_minutes     = min_acc;
                    saved_thousandths = frac_acc;
                    saved_south       = hemi_south;
                end
                result.lat_degrees       = saved_degrees;
                result.lat_minutes       = saved_minutes;
                result.lat_thousandths   = saved_thousandths;
                result.lat_south         = saved_south;
                result.line_was_sentence = line_is_sentence;
                result.line_was_rmc      = rmc;
                result.fix_updated       = updated;
                produced = 1'b1;
                clear_line_state();
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string field, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0d, actual %0d", field, want, got));
    endtask

    // Predict on every accepted byte request and compare every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        logic        produced;
        fix_result_t predicted;
        fix_result_t want;
        if (!rst_n)
        begin
            clear_line_state();
            saved_degrees     = '0;
            saved_minutes     = '0;
            saved_thousandths = '0;
            saved_south       = 1'b0;
            expected_fixes.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_fixes <= 0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                parse_nmea_char(rx.rx_byte, produced, predicted);
                if (produced)
                    expected_fixes.push_back(predicted);
            end
            if (fix.valid && fix.ready)
            begin
                if (expected_fixes.size() == 0)
                    note_mismatch("result with no line ended");
                else
                begin
                    want = expected_fixes.pop_front();
                    check_field("lat_degrees", want.lat_degrees, fix.lat_degrees);
                    check_field("lat_minutes", want.lat_minutes, fix.lat_minutes);
                    check_field("lat_thousandths", want.lat_thousandths, fix.lat_thousandths);
                    check_field("lat_south", want.lat_south, fix.lat_south);
                    check_field("line_was_sentence", want.line_was_sentence,
                                fix.line_was_sentence);
                    check_field("line_was_rmc", want.line_was_rmc, fix.line_was_rmc);
                    check_field("fix_updated", want.fix_updated, fix.fix_updated);
                end
            end
            fail_count    <= mismatches;
            pending_fixes <= expected_fixes.size();
        end
    end

endmodule

// ===== test/tb_nmea_rmc_latitude_parser_top.sv =====
`timescale 1ns / 100ps

module tb_nmea_rmc_latitude_parser_top;
    import nmea_lat_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_BYTES    = 700;
    localparam int FIX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;

    logic       clk;
    logic       rst_n;
    logic       steady_phase;
    int         fix_hold_requests;
    int         cycle_count;
    int         fail_count;
    int         pending_fixes;
    int         bytes_sent;
    logic [7:0] line_bytes[$];

    nmea_lat_byte_if rx_bus();
    nmea_lat_fix_if  fix_bus();

    nmea_rmc_latitude_parser_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .fix   (fix_bus)
    );

    nmea_rmc_latitude_checker lat_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_bus),
        .fix           (fix_bus),
        .fail_count    (fail_count),
        .pending_fixes (pending_fixes)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL nmea_rmc_latitude_parser_top");
            $finish;
        end
    end

    // Result side: random stalls, none in the steady phase, and long holds on request.
    initial
    begin
        int holds_done;
        holds_done = 0;
        fix_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (fix_hold_requests != holds_done)
            begin
                holds_done++;
                fix_bus.ready <= 1'b0;
                repeat (FIX_HOLD_CYCLES) @(posedge clk);
            end
            else
                fix_bus.ready <= steady_phase || ($urandom_range(99) >= 19);
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic push_digits(input int count);
        repeat (count) line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    // Offers one byte request and returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] c);
        while (!steady_phase && $urandom_range(99) < 19)
        begin
            rx_bus.valid <= 1'b0;
            @(posedge clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= c;
        @(posedge clk);
        while (!rx_bus.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
    endtask

    task automatic send_text(input string s);
        line_bytes.delete();
        push_text(s);
        send_line();
    endtask

    // Stops offering and waits until every predicted result has been compared.
    task automatic wait_for_fixes();
        rx_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_fixes != 0);
    endtask

    // A mostly well-formed RMC sentence with random fields and occasional defects.
    task automatic build_rmc_line();
        int pick;
        line_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 85)
            push_text("$GPRMC");
        else
        begin
            case (pick % 5)
                0:       push_text("GPRMC");
                1:       push_text("$GPGGA");
                2:       push_text("$GPRM");
                3:       push_text("$$GPRMC");
                default: push_text("$GPRMCX");
            endcase
        end
        push_text(",");
        push_digits(6);
        if ($urandom_range(9) != 0)
        begin
            push_text(".");
            push_digits(2);
        end
        push_text(",");

        pick = $urandom_range(99);
        if (pick < 80)
            push_text("A");
        else if (pick < 95)
            push_text("V");
        else
            line_bytes.push_back(8'($urandom_range(1, 255)));
        push_text(",");

        // Latitude degrees and minutes, sometimes odd lengths or a stray character.
        if ($urandom_range(9) < 8)
            push_digits(4);
        else
        begin
            push_digits($urandom_range(0, 7));
            if ($urandom_range(1) == 1)
                line_bytes.push_back(8'($urandom_range(32, 126)));
            push_digits($urandom_range(0, 2));
        end
        if ($urandom_range(9) != 0)
        begin
            push_text(".");
            if ($urandom_range(9) < 8)
                push_digits(3);
            else
                push_digits($urandom_range(0, 6));
        end

        pick = $urandom_range(99);
        if (pick < 45)
            push_text(",N");
        else if (pick < 90)
            push_text(",S");
        else if (pick < 95)
        begin
            push_text(",");
            line_bytes.push_back(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(1) == 1)
            push_text(",01131.000,E,022.4,084.4,230394,003.1,W*6A");
        if ($urandom_range(9) == 0)
            push_text("\r");
        push_text("\n");
    endtask

    // Random bytes of any value, sometimes opened with a dollar sign.
    task automatic build_noise_line();
        line_bytes.delete();
        if ($urandom_range(9) < 3)
            push_text("$");
        repeat ($urandom_range(0, 40)) line_bytes.push_back(8'($urandom_range(0, 255)));
        push_text("\n");
    endtask

    initial
    begin
        int pick;
        int line_no;
        int cut;
        rst_n          <= 1'b0;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= CH_NUL;
        steady_phase   <= 1'b0;
        fix_hold_requests = 0;
        cycle_count       = 0;
        bytes_sent        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: plain fixes, field extremes and each malformed form.
        send_text("\n");
        // The result side holds off while short lines keep coming, so the input stalls.
        fix_hold_requests <= fix_hold_requests + 1;
        send_text("$GPRMC,123519.00,A,4807.038,N,01131.000,E*6A\r\n");
        send_text("$GPRMC,1.2,A,9959.999,S\n");
        send_text("$GPRMC,1.2,A,0099999.1234,N\n");
        send_text("$GPRMC,1.2,V,1234.567,S\n");
        send_text("$GPRMC,1.2,\n");
        send_text("GPRMC,1.2,A,1234.567,S\n");
        send_text("$GPGGA,1.2,A,1234.567,S\n");
        send_text("$GPRM,1.2,A,1234.567,S\n");
        send_text("$GPRMCZ,1.2,AV,1234.567,W\n");
        send_text("$GPRMC,1.2,A,4x07.0a5,S\n");
        send_text("$GPRMC,1.2,A, 4807.-12,S\n");
        send_text("$GPRMC,1.2,A,4.7,\n");
        send_text("$GPRMC,1.2,A,48\n");
        send_text("$$GPRMC,,1..2,,A,,1234,,567,,,S,a,b,c,d,e,f,g,h,i,j,k\n");
        send_text("$GPRMC\n");
        send_text("$\n");

        // Zero bytes are dropped anywhere, including at the start of a line.
        line_bytes.delete();
        line_bytes.push_back(CH_NUL);
        push_text("$GP");
        line_bytes.push_back(CH_NUL);
        push_text("RMC,1.2,A,2233.445,S");
        line_bytes.push_back(CH_NUL);
        push_text("\n");
        send_line();

        // Very long tokens saturate the position counter.
        line_bytes.delete();
        push_text("$GPRMC");
        repeat (300) push_text("X");
        push_text(",1.2,A,1111.111,S\n");
        send_line();
        line_bytes.delete();
        push_text("$GPRMC,1.2,A,12");
        push_digits(300);
        push_text(".5,N\n");
        send_line();

        // Pause until every result so far has been checked.
        wait_for_fixes();

        // Random lines: mostly sentences, some truncated, some noise, a few very long.
        bytes_sent = 0;
        line_no    = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            line_no++;
            if (line_no == 1)
                steady_phase <= 1'b1;
            if (line_no == 8)
                steady_phase <= 1'b0;

            pick = $urandom_range(99);
            if (pick < 75)
                build_rmc_line();
            else if (pick < 85)
            begin
                build_rmc_line();
                cut = $urandom_range(1, line_bytes.size() - 1);
                while (line_bytes.size() > cut)
                    void'(line_bytes.pop_back());
                push_text("\n");
            end
            else if (pick < 97)
                build_noise_line();
            else
            begin
                line_bytes.delete();
                push_text("$GPRMC,1.2,A,");
                push_digits($urandom_range(200, 280));
                push_text(".5,S\n");
            end
            if ($urandom_range(9) == 0)
                line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CH_NUL);
            send_line();
        end

        wait_for_fixes();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS nmea_rmc_latitude_parser_top");
        else
            $display("FAIL nmea_rmc_latitude_parser_top");
        $finish;
    end

endmodule
